@@ rtl/bgsc_pkg.sv @@
// bgsc_pkg: shared types and constants for the barrier gate safety controller
// no dependencies

package bgsc_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 20;
	localparam int unsigned STABLE_W   = 16;
	localparam int unsigned OPEN_W     = 20;
	localparam int unsigned ANGLE_W    = 8;

	localparam logic [STABLE_W-1:0] STABLE_MAX = 16'hFFFF;
	localparam logic [OPEN_W-1:0]   OPEN_MAX   = 20'hFFFFF;
	localparam logic [ANGLE_W-1:0]  ANGLE_MAX  = 8'd180;

	localparam logic [STABLE_W-1:0] DEBOUNCE_RST  = 16'd100;
	localparam logic [OPEN_W-1:0]   AUTOCLOSE_RST = 20'd5000;
	localparam logic [ANGLE_W-1:0]  OPEN_ANG_RST  = 8'd90;
	localparam logic [ANGLE_W-1:0]  CLOSE_ANG_RST = 8'd0;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_OPEN  = 2'd1,
		REQ_CLOSE = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_OPENED  = 3'd1,
		EV_CLOSED  = 3'd2,
		EV_BLOCKED = 3'd3,
		EV_CAR     = 3'd4
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE  = 2'd0,
		CFG_AUTOCLOSE = 2'd1,
		CFG_OPEN_ANG  = 2'd2,
		CFG_CLOSE_ANG = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [STABLE_W-1:0] debounce_ms;
		logic [OPEN_W-1:0]   auto_close_ms;
		logic [ANGLE_W-1:0]  open_angle;
		logic [ANGLE_W-1:0]  closed_angle;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         event_res;
		logic               gate_open;
		logic               car_present;
		logic [ANGLE_W-1:0] servo_angle;
	} res_t;

endpackage

@@ rtl/bgsc_if.sv @@
// bgsc_req_if, bgsc_res_if: valid/ready channels for request and result words
// depends on bgsc_pkg

interface bgsc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       car_sample;

	modport source (output valid, output req_type, output car_sample, input ready);
	modport sink (input valid, input req_type, input car_sample, output ready);
endinterface

interface bgsc_res_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    event_res;
	logic                          gate_open;
	logic                          car_present;
	logic [bgsc_pkg::ANGLE_W-1:0]  servo_angle;

	modport source (output valid, output event_res, output gate_open, output car_present,
		output servo_angle, input ready);
	modport sink (input valid, input event_res, input gate_open, input car_present,
		input servo_angle, output ready);
endinterface

@@ rtl/bgsc_cfg_regs.sv @@
// bgsc_cfg_regs: write-only configuration registers
// depends on bgsc_pkg

module bgsc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [bgsc_pkg::CFG_IDX_W-1:0]      idx,
	input  logic [bgsc_pkg::CFG_DATA_W-1:0]     wdata,
	output bgsc_pkg::cfg_t                      cfg
);

	bgsc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= bgsc_pkg::DEBOUNCE_RST;
			cfg_q.auto_close_ms <= bgsc_pkg::AUTOCLOSE_RST;
			cfg_q.open_angle    <= bgsc_pkg::OPEN_ANG_RST;
			cfg_q.closed_angle  <= bgsc_pkg::CLOSE_ANG_RST;
		end else if (we) begin
			unique case (bgsc_pkg::cfg_idx_t'(idx))
				bgsc_pkg::CFG_DEBOUNCE: begin
					cfg_q.debounce_ms <= wdata[bgsc_pkg::STABLE_W-1:0];
				end
				bgsc_pkg::CFG_AUTOCLOSE: begin
					cfg_q.auto_close_ms <= wdata[bgsc_pkg::OPEN_W-1:0];
				end
				bgsc_pkg::CFG_OPEN_ANG: begin
					cfg_q.open_angle <= wdata[bgsc_pkg::ANGLE_W-1:0];
				end
				bgsc_pkg::CFG_CLOSE_ANG: begin
					cfg_q.closed_angle <= wdata[bgsc_pkg::ANGLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/bgsc_step.sv @@
// bgsc_step: debounce and gate state registers with their single-pass update
// depends on bgsc_pkg

module bgsc_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [1:0]            req_type,
	input  logic                  car_sample,
	input  bgsc_pkg::cfg_t        cfg,
	output bgsc_pkg::res_t        res
);

	logic                          last_sample_q;
	logic                          car_stable_q;
	logic [bgsc_pkg::STABLE_W-1:0] stable_time_q;
	logic                          gate_is_open_q;
	logic [bgsc_pkg::OPEN_W-1:0]   open_time_q;

	logic                          last_sample_d;
	logic                          car_stable_d;
	logic [bgsc_pkg::STABLE_W-1:0] stable_time_d;
	logic                          gate_is_open_d;
	logic [bgsc_pkg::OPEN_W-1:0]   open_time_d;
	bgsc_pkg::event_t              ev;
	logic [bgsc_pkg::ANGLE_W-1:0]  angle_raw;

	always_comb begin
		last_sample_d  = last_sample_q;
		car_stable_d   = car_stable_q;
		stable_time_d  = stable_time_q;
		gate_is_open_d = gate_is_open_q;
		open_time_d    = open_time_q;
		ev             = bgsc_pkg::EV_NONE;

		case (req_type)
			bgsc_pkg::REQ_TICK: begin
				if (gate_is_open_q && open_time_q != bgsc_pkg::OPEN_MAX)
					open_time_d = open_time_q + 1'b1;
				if (car_sample != last_sample_q) begin
					last_sample_d = car_sample;
					stable_time_d = '0;
				end else begin
					if (stable_time_q != bgsc_pkg::STABLE_MAX)
						stable_time_d = stable_time_q + 1'b1;
					if (car_sample != car_stable_q && stable_time_d >= cfg.debounce_ms) begin
						car_stable_d = car_sample;
						ev           = bgsc_pkg::EV_CAR;
						if (gate_is_open_q && !car_sample)
							open_time_d = '0;
					end
				end
				if (gate_is_open_q) begin
					if (car_stable_d) begin
						open_time_d = '0;
					end else if (open_time_d >= cfg.auto_close_ms) begin
						gate_is_open_d = 1'b0;
						ev             = bgsc_pkg::EV_CLOSED;
					end
				end
			end
			bgsc_pkg::REQ_OPEN: begin
				gate_is_open_d = 1'b1;
				open_time_d    = '0;
				ev             = bgsc_pkg::EV_OPENED;
			end
			bgsc_pkg::REQ_CLOSE: begin
				if (car_stable_q) begin
					ev = bgsc_pkg::EV_BLOCKED;
				end else begin
					gate_is_open_d = 1'b0;
					ev             = bgsc_pkg::EV_CLOSED;
				end
			end
			default: begin
			end
		endcase

		angle_raw = gate_is_open_d ? cfg.open_angle : cfg.closed_angle;

		res.event_res   = ev;
		res.gate_open   = gate_is_open_d;
		res.car_present = car_stable_d;
		res.servo_angle = (angle_raw > bgsc_pkg::ANGLE_MAX) ? bgsc_pkg::ANGLE_MAX : angle_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q  <= 1'b0;
			car_stable_q   <= 1'b0;
			stable_time_q  <= '0;
			gate_is_open_q <= 1'b0;
			open_time_q    <= '0;
		end else if (en) begin
			last_sample_q  <= last_sample_d;
			car_stable_q   <= car_stable_d;
			stable_time_q  <= stable_time_d;
			gate_is_open_q <= gate_is_open_d;
			open_time_q    <= open_time_d;
		end
	end

endmodule

@@ rtl/barrier_gate_safety_controller.sv @@
// barrier_gate_safety_controller: top level, input register, state update, result register
// depends on bgsc_pkg, bgsc_if, bgsc_cfg_regs, bgsc_step

// Takes one request word per clock (a one-millisecond tick with its raw car
// sample, an open command or a close command) and returns exactly one result
// word for each from the result register. A word is registered on entry,
// the debounce and gate state are updated by one pass of logic between that
// register and the result register, so a new word can enter every cycle and
// throughput is one word per clock while the result side keeps up; a stalled
// result holds the pipeline. Configuration (debounce_ms, auto_close_ms,
// open_angle, closed_angle at indexes 0 to 3) is written through cfg_we,
// cfg_index and cfg_data while no word is in flight.
module barrier_gate_safety_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	bgsc_req_if.sink                        req_ch,
	bgsc_res_if.source                      res_ch,
	input  logic                            cfg_we,
	input  logic [bgsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgsc_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic           valid_s1;
	logic [1:0]     req_type_s1;
	logic           car_sample_s1;
	logic           out_valid_q;
	bgsc_pkg::res_t out_q;
	bgsc_pkg::res_t res_d;
	bgsc_pkg::cfg_t cfg;
	logic           advance;

	assign advance      = valid_s1 && (!out_valid_q || res_ch.ready);
	assign req_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ch.ready) begin
			valid_s1 <= req_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ch.ready && req_ch.valid) begin
			req_type_s1   <= req_ch.req_type;
			car_sample_s1 <= req_ch.car_sample;
		end
	end

	bgsc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_index),
		.wdata  (cfg_data),
		.cfg    (cfg)
	);

	bgsc_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.req_type   (req_type_s1),
		.car_sample (car_sample_s1),
		.cfg        (cfg),
		.res        (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res_d;
		end
	end

	assign res_ch.valid       = out_valid_q;
	assign res_ch.event_res   = out_q.event_res;
	assign res_ch.gate_open   = out_q.gate_open;
	assign res_ch.car_present = out_q.car_present;
	assign res_ch.servo_angle = out_q.servo_angle;

endmodule

@@ rtl/bgsc_checker.sv @@
// bgsc_checker: port-level checks on result words of the top level
// depends on bgsc_pkg; bound to barrier_gate_safety_controller

module bgsc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [2:0]                     event_res,
	input logic                           gate_open,
	input logic                           car_present,
	input logic [bgsc_pkg::ANGLE_W-1:0]   servo_angle
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(event_res) && $stable(gate_open))
		else $error("result word dropped while stalled");

	a_opened: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == bgsc_pkg::EV_OPENED |-> gate_open)
		else $error("opened word with gate closed");

	a_closed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == bgsc_pkg::EV_CLOSED |-> !gate_open && !car_present)
		else $error("closed word with gate open or car present");

	a_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == bgsc_pkg::EV_BLOCKED |-> car_present)
		else $error("close blocked without a car present");

	a_angle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> servo_angle <= bgsc_pkg::ANGLE_MAX)
		else $error("servo angle out of range");

endmodule

bind barrier_gate_safety_controller bgsc_checker u_bgsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_ch.valid),
	.res_ready   (res_ch.ready),
	.event_res   (res_ch.event_res),
	.gate_open   (res_ch.gate_open),
	.car_present (res_ch.car_present),
	.servo_angle (res_ch.servo_angle)
);
